@@ sv/rpg_pkg.sv @@
// ----------------------------------------------------------------------------
// rpg_pkg
// shared types, constants and helpers of the rainbow pixel generator
// ----------------------------------------------------------------------------
package rpg_pkg;

   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 10;
   localparam int COUNT_W     = 11;
   localparam int HUE_W       = 8;
   localparam int DIVIDEND_W  = INDEX_W + HUE_W;
   localparam int DIV_STEPS   = 3;
   localparam int DIV_STAGES  = DIVIDEND_W / DIV_STEPS;
   localparam int CSR_INDEX_W = 2;
   localparam int PROD_W      = 2 * CHAN_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUE_STEP   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_LEN  = 2'd2;

   localparam logic [CHAN_W-1:0]  BRIGHTNESS_RST = 8'd150;
   localparam logic [HUE_W-1:0]   HUE_STEP_RST   = 8'd5;
   localparam logic [COUNT_W-1:0] STRIP_LEN_RST  = 11'd247;

   localparam logic [CHAN_W-1:0] WHEEL_SEG1 = 8'd85;
   localparam logic [CHAN_W-1:0] WHEEL_SEG2 = 8'd170;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

   typedef struct packed {
      logic [COUNT_W-1:0]    rem;
      logic [DIVIDEND_W-1:0] dvd;
      logic [HUE_W-1:0]      quo;
      logic [HUE_W-1:0]      hue;
      logic                  zero;
   } div_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   // floor(x / 255) for x up to 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] sum;
      sum = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
      return sum[PROD_W-1:CHAN_W];
   endfunction

endpackage

@@ sv/rpg_div_stage.sv @@
// ----------------------------------------------------------------------------
// rpg_div_stage
// one register stage of the restoring divider, DIV_STEPS quotient bits per stage
// ----------------------------------------------------------------------------
module rpg_div_stage
   import rpg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] divisor,
   input  logic               in_valid,
   output logic               in_ready,
   input  div_type            in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output div_type            out_data
);

   logic          valid_ff;
   div_type       data_ff;
   div_type       data_in;
   logic [COUNT_W:0] shifted;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      shifted = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         shifted     = {data_in.rem, data_in.dvd[DIVIDEND_W-1]};
         data_in.dvd = {data_in.dvd[DIVIDEND_W-2:0], 1'b0};
         if (shifted >= {1'b0, divisor}) begin
            shifted     = shifted - {1'b0, divisor};
            data_in.quo = {data_in.quo[HUE_W-2:0], 1'b1};
         end else begin
            data_in.quo = {data_in.quo[HUE_W-2:0], 1'b0};
         end
         data_in.rem = shifted[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ sv/rpg_color.sv @@
// ----------------------------------------------------------------------------
// rpg_color
// adds the frame hue to the pixel offset and maps it through the colour wheel
// ----------------------------------------------------------------------------
module rpg_color
   import rpg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rgb_type out_data
);

   logic              valid_ff;
   rgb_type           rgb_ff;
   rgb_type           rgb_in;
   logic [HUE_W-1:0]  offset;
   logic [HUE_W-1:0]  pos;
   logic [CHAN_W-1:0] p;
   logic [CHAN_W-1:0] q;
   logic [CHAN_W-1:0] q3;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = rgb_ff;

   always_comb begin
      offset = in_data.zero ? '0 : in_data.quo;
      pos    = in_data.hue + offset;
      p      = ~pos;
      if (p < WHEEL_SEG1) begin
         q = p;
      end else if (p < WHEEL_SEG2) begin
         q = p - WHEEL_SEG1;
      end else begin
         q = p - WHEEL_SEG2;
      end
      q3 = {q[CHAN_W-2:0], 1'b0} + q;
      if (p < WHEEL_SEG1) begin
         rgb_in.red   = CHAN_MAX - q3;
         rgb_in.green = '0;
         rgb_in.blue  = q3;
      end else if (p < WHEEL_SEG2) begin
         rgb_in.red   = '0;
         rgb_in.green = q3;
         rgb_in.blue  = CHAN_MAX - q3;
      end else begin
         rgb_in.red   = q3;
         rgb_in.green = CHAN_MAX - q3;
         rgb_in.blue  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         rgb_ff <= rgb_in;
      end
   end

endmodule

@@ sv/rpg_scale.sv @@
// ----------------------------------------------------------------------------
// rpg_scale
// brightness scaling: product stage, then divide by 255 into the output register
// ----------------------------------------------------------------------------
module rpg_scale
   import rpg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAN_W-1:0] brightness,
   input  logic              in_valid,
   output logic              in_ready,
   input  rgb_type           in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rgb_type           out_data
);

   logic              prod_valid_ff;
   logic [PROD_W-1:0] red_prod_ff;
   logic [PROD_W-1:0] green_prod_ff;
   logic [PROD_W-1:0] blue_prod_ff;
   logic              out_valid_ff;
   rgb_type           out_ff;
   logic              out_stage_ready;

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign in_ready        = !prod_valid_ff || out_stage_ready;
   assign out_valid       = out_valid_ff;
   assign out_data        = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (out_stage_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         red_prod_ff   <= in_data.red * brightness;
         green_prod_ff <= in_data.green * brightness;
         blue_prod_ff  <= in_data.blue * brightness;
      end
      if (out_stage_ready && prod_valid_ff) begin
         out_ff.red   <= div255(red_prod_ff);
         out_ff.green <= div255(green_prod_ff);
         out_ff.blue  <= div255(blue_prod_ff);
      end
   end

endmodule

@@ sv/rainbow_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// rainbow_pixel_generator
// streaming rainbow colour generator for an led strip
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result side keeps up. A pixel
// transaction (tuser 0) returns its colour through the six-stage divider that
// forms index*256/strip length three quotient bits per stage, then the colour
// wheel stage and the two brightness stages. A frame transaction (tuser 1)
// moves the hue on at once and returns nothing. Every stage holds on its own,
// so bubbles close up while the result side stalls. Write the registers only
// while no pixel is in flight.
// ----------------------------------------------------------------------------
module rainbow_pixel_generator
   import rpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // pixel_index, zero pad
   input  logic                   req_tuser,   // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // red, green, blue
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]     csr_wdata
);

   logic [CHAN_W-1:0]  brightness_ff;
   logic [HUE_W-1:0]   hue_step_ff;
   logic [COUNT_W-1:0] strip_len_ff;
   logic [HUE_W-1:0]   frame_hue_ff;
   logic [HUE_W:0]     hue_sum;

   logic    div_valid [0:DIV_STAGES];
   logic    div_ready [0:DIV_STAGES];
   div_type div_data  [0:DIV_STAGES];

   logic    color_valid;
   logic    color_ready;
   rgb_type color_data;
   rgb_type rsp_data;

   assign hue_sum = {1'b0, frame_hue_ff} + {1'b0, hue_step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RST;
         hue_step_ff   <= HUE_STEP_RST;
         strip_len_ff  <= STRIP_LEN_RST;
         frame_hue_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BRIGHTNESS: brightness_ff <= csr_wdata[CHAN_W-1:0];
               CSR_HUE_STEP:   hue_step_ff   <= csr_wdata[HUE_W-1:0];
               CSR_STRIP_LEN:  strip_len_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready && req_tuser) begin
            frame_hue_ff <= hue_sum[HUE_W] ? '0 : hue_sum[HUE_W-1:0];
         end
      end
   end

   // pixel transactions enter the divider with the hue current at acceptance
   assign req_tready       = div_ready[0];
   assign div_valid[0]     = req_tvalid && !req_tuser;
   assign div_data[0].rem  = '0;
   assign div_data[0].dvd  = {req_tdata[INDEX_W-1:0], {HUE_W{1'b0}}};
   assign div_data[0].quo  = '0;
   assign div_data[0].hue  = frame_hue_ff;
   assign div_data[0].zero = (strip_len_ff == '0);

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rpg_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .divisor   (strip_len_ff),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   rpg_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[DIV_STAGES]),
      .in_ready  (div_ready[DIV_STAGES]),
      .in_data   (div_data[DIV_STAGES]),
      .out_valid (color_valid),
      .out_ready (color_ready),
      .out_data  (color_data)
   );

   rpg_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .brightness (brightness_ff),
      .in_valid   (color_valid),
      .in_ready   (color_ready),
      .in_data    (color_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_data)
   );

   assign rsp_tdata = {rsp_data.blue, rsp_data.green, rsp_data.red};

endmodule

@@ tb/sv/rpg_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rpg_tb_pkg
// codes shared by the rainbow pixel generator testbench and its checker
// ----------------------------------------------------------------------------
package rpg_tb_pkg;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_FRAME = 1'b1
   } action_type;

endpackage

@@ tb/sv/rpg_checker.sv @@
// ----------------------------------------------------------------------------
// rpg_checker
// colour predictor and scoreboard for the rainbow pixel generator
// ----------------------------------------------------------------------------
// Watches the request, result and register ports. Register writes update a
// local copy of the settings. Each accepted pixel transaction is turned into
// an expected colour from the current hue, led count and brightness. Each
// frame transaction moves the local hue on. Results are compared in order,
// channel by channel, and failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module rpg_checker
   import rpg_pkg::*;
   import rpg_tb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [15:0]            req_tdata,   // pixel_index, zero pad
   input  logic                   req_tuser,   // action
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [23:0]            rsp_tdata,   // red, green, blue
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]     csr_wdata,
   output int                     fail_count,
   output int                     colours_due,
   output int                     colours_checked
);

   logic [CHAN_W-1:0]  brightness_q = BRIGHTNESS_RST;
   logic [HUE_W-1:0]   hue_step_q   = HUE_STEP_RST;
   logic [COUNT_W-1:0] strip_len_q  = STRIP_LEN_RST;
   logic [HUE_W-1:0]   frame_hue    = '0;
   rgb_type            colour_q[$];
   int                 fails        = 0;
   int                 due          = 0;
   int                 checked      = 0;

   assign fail_count      = fails;
   assign colours_due     = due;
   assign colours_checked = checked;

   function automatic logic [CHAN_W-1:0] dim(input int unsigned level);
      return CHAN_W'((level * brightness_q) / CHAN_MAX);
   endfunction

   function automatic rgb_type pixel_colour(input logic [INDEX_W-1:0] idx);
      int unsigned offset, pos, p, q, r, g, b;
      rgb_type     c;
      offset = (strip_len_q == '0) ? 0 : (idx * 32'd256) / strip_len_q;
      pos    = (frame_hue + offset) % 256;
      p      = CHAN_MAX - pos;
      if (p < WHEEL_SEG1) begin
         r = CHAN_MAX - 3 * p;
         g = 0;
         b = 3 * p;
      end else if (p < WHEEL_SEG2) begin
         q = p - WHEEL_SEG1;
         r = 0;
         g = 3 * q;
         b = CHAN_MAX - 3 * q;
      end else begin
         q = p - WHEEL_SEG2;
         r = 3 * q;
         g = CHAN_MAX - 3 * q;
         b = 0;
      end
      c.red   = dim(r);
      c.green = dim(g);
      c.blue  = dim(b);
      return c;
   endfunction

   always @(posedge clock) begin : scoreboard
      rgb_type     want, got;
      int unsigned sum;
      if (reset) begin
         brightness_q = BRIGHTNESS_RST;
         hue_step_q   = HUE_STEP_RST;
         strip_len_q  = STRIP_LEN_RST;
         frame_hue    = '0;
         colour_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rgb_type'(rsp_tdata);
            if (colour_q.size() == 0) begin
               $error("result transaction with no colour expected: %h", rsp_tdata);
               fails++;
            end else begin
               want = colour_q.pop_front();
               checked++;
               if (got.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, got.red);
                  fails++;
               end
               if (got.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, got.green);
                  fails++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, got.blue);
                  fails++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BRIGHTNESS: brightness_q = csr_wdata[CHAN_W-1:0];
               CSR_HUE_STEP:   hue_step_q   = csr_wdata[HUE_W-1:0];
               CSR_STRIP_LEN:  strip_len_q  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (action_type'(req_tuser) == ACT_FRAME) begin
               sum       = frame_hue + hue_step_q;
               frame_hue = (sum >= 256) ? '0 : HUE_W'(sum);
            end else begin
               colour_q.push_back(pixel_colour(req_tdata[INDEX_W-1:0]));
            end
         end
      end
      due = colour_q.size();
   end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// testbench top for the rainbow pixel generator
// ----------------------------------------------------------------------------
// A short directed run covers the colour wheel boundaries, hue overflow, a
// zero hue step, zero and oversized led counts and brightness extremes. Then
// random phases, each under a fresh register setting, send pixel sweeps in
// index order closed by frame transactions, mixed with random transactions.
// Both sides idle at random; one phase holds the result side off for a long
// stretch. The checker predicts and compares every colour.
// ----------------------------------------------------------------------------
module tb;
   import rpg_pkg::*;
   import rpg_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1830;
   localparam int PHASE_ITEMS  = 230;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_WAIT   = 12;
   localparam int WATCHDOG     = 2000;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata  = '0;   // pixel_index, zero pad
   logic                   req_tuser  = ACT_PIXEL;   // action
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;   // red, green, blue
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_BRIGHTNESS;
   logic [COUNT_W-1:0]     csr_wdata  = '0;

   int fail_count, colours_due, colours_checked;
   int pixels_sent   = 0;
   int frames_sent   = 0;
   int settings_done = 0;
   int idle_cycles   = 0;

   bit req_idle_on    = 1'b0;
   bit rsp_idle_on    = 1'b0;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;

   logic [COUNT_W-1:0] led_now = STRIP_LEN_RST;

   rainbow_pixel_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rpg_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .colours_due     (colours_due),
      .colours_checked (colours_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("rainbow_pixel_generator test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, plus one long hold when asked
   always @(posedge clock) begin : rsp_side
      int  stall_left;
      bit  ready_next;
      if (long_hold_req && !long_hold_done) begin
         stall_left     = LONG_HOLD;
         long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 20) begin
         stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(15, 60);
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
      end
      rsp_tready <= ready_next;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!req_idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send(input action_type act, input logic [INDEX_W-1:0] idx);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(16-INDEX_W){1'b0}}, idx};
      do @(posedge clock); while (!req_tready);
      if (act == ACT_FRAME) frames_sent++;
      else pixels_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [COUNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CHAN_W-1:0] br, input logic [HUE_W-1:0] step,
                                input logic [COUNT_W-1:0] leds);
      write_reg(CSR_BRIGHTNESS, {{(COUNT_W-CHAN_W){1'b0}}, br});
      write_reg(CSR_HUE_STEP, {{(COUNT_W-HUE_W){1'b0}}, step});
      write_reg(CSR_STRIP_LEN, leds);
      led_now = leds;
      settings_done++;
   endtask

   task automatic random_setting();
      logic [CHAN_W-1:0]  br;
      logic [HUE_W-1:0]   step;
      logic [COUNT_W-1:0] leds;
      case ($urandom_range(0, 3))
         0:       br = '0;
         1:       br = CHAN_MAX;
         default: br = CHAN_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 4))
         0:       step = '0;
         1:       step = 8'd1;
         2:       step = 8'd255;
         default: step = HUE_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 6))
         0:       leds = '0;
         1:       leds = 11'd1;
         2:       leds = 11'd1024;
         3:       leds = 11'd2047;
         default: leds = COUNT_W'($urandom_range(1, 1024));
      endcase
      apply_setting(br, step, leds);
   endtask

   // wait for every colour in flight, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (colours_due == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned lim, start, len, sent;
      int          phase;
      int          budget;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // wheel segment boundaries at hue zero
      write_reg(CSR_STRIP_LEN, 11'd256);
      led_now = 11'd256;
      send(ACT_PIXEL, 10'd0);
      send(ACT_PIXEL, 10'd84);
      send(ACT_PIXEL, 10'd85);
      send(ACT_PIXEL, 10'd86);
      send(ACT_PIXEL, 10'd169);
      send(ACT_PIXEL, 10'd170);
      send(ACT_PIXEL, 10'd171);
      send(ACT_PIXEL, 10'd255);
      drain();

      // full brightness, hue overflow
      apply_setting(8'd255, 8'd255, 11'd1024);
      send(ACT_FRAME, 10'd0);
      send(ACT_FRAME, 10'd0);
      send(ACT_PIXEL, 10'd0);
      send(ACT_PIXEL, 10'd1023);
      drain();

      // zero brightness, zero hue step, zero led count
      apply_setting(8'd0, 8'd0, 11'd0);
      send(ACT_PIXEL, 10'd1023);
      send(ACT_FRAME, 10'd1023);
      send(ACT_PIXEL, 10'd7);
      drain();

      // led count above the index range
      apply_setting(8'd1, 8'd1, 11'd2047);
      send(ACT_PIXEL, 10'd1023);
      send(ACT_FRAME, 10'd0);
      send(ACT_PIXEL, 10'd512);
      drain();

      // single led, index far beyond it
      apply_setting(8'd200, 8'd37, 11'd1);
      send(ACT_PIXEL, 10'd1023);
      drain();

      sent = 0;
      for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
         random_setting();
         req_idle_on = (phase % 3 != 0) && (phase != 2);
         rsp_idle_on = (phase % 4 != 1);
         if (phase == 2) long_hold_req = 1'b1;
         budget = 0;
         while (budget < PHASE_ITEMS && sent + budget < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
               lim   = (led_now == '0 || led_now > 11'd1024) ? 1024 : led_now;
               start = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, lim - 1);
               len   = $urandom_range(1, 48);
               for (int unsigned k = 0; k < len; k++)
                  send(ACT_PIXEL, INDEX_W'((start + k) % lim));
               send(ACT_FRAME, INDEX_W'($urandom_range(0, 1023)));
               budget += len + 1;
            end else begin
               len = $urandom_range(1, 6);
               repeat (len) begin
                  send(action_type'($urandom_range(0, 1)),
                       INDEX_W'($urandom_range(0, 1023)));
               end
               budget += len;
            end
         end
         sent += budget;
         drain();
      end

      $display("sent %0d pixel and %0d frame transactions under %0d register settings",
               pixels_sent, frames_sent, settings_done);
      $display("checked %0d colours, including a long result hold and full drains",
               colours_checked);
      if (fail_count == 0) begin
         $display("rainbow_pixel_generator test passed");
      end else begin
         $display("rainbow_pixel_generator test failed");
      end
      $finish;
   end

endmodule
